### design/spd_pkg.sv
// Shared types and codes for the sorted priority deque.
package spd_pkg;

    localparam int IN_W  = 56;
    localparam int OUT_W = 56;
    localparam int OCC_W = 5;

    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_RM_FRONT = 3'd1;
    localparam logic [2:0] MODE_RM_BACK  = 3'd2;
    localparam logic [2:0] MODE_PEEK     = 3'd3;
    localparam logic [2:0] MODE_SEARCH   = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [15:0] duration;
        logic [7:0]  kind;
        logic [15:0] id;
        logic [7:0]  prio;
    } entry_t;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'b001,
        CELL_INSERT = 3'b010,
        CELL_ROTATE = 3'b100
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

    typedef struct packed {
        logic [OCC_W-1:0] occ;
        entry_t           entry;
        logic [1:0]       status;
    } result_t;

endpackage

### design/sorted_priority_deque.sv
// Top level of the sorted priority deque: cell chain, operation control and result staging.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata: mode, job_prio, job_id, job_kind,
//          |           |                    |          job_duration
//  m_      | out       | m_tvalid/m_tready  | m_tdata: status, out_priority, out_id, out_kind,
//          |           |                    |          out_duration, occupancy
//
// Insert, remove front, peek and unused codes need no scan: the whole chain compares and
//   shifts in parallel, so one such transaction is accepted every cycle unless the output stalls with a result staged.
// Search and remove back on a non-empty queue run a scan: the chain rotates one full turn past
//   the head cell, which is examined once per step.
// Reset (aresetn low, synchronous) clears the entry count, the control state and the result
//   staging; slot contents are not cleared, entries beyond the count are never reported.
// A result waits in a staging register while the output register is stalled, so one more
//   transaction is taken; the scan holds on its last step until the staging register frees.
module sorted_priority_deque
    import spd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    // s_tdata, lowest bit up: mode[2:0], job_prio[10:3], job_id[26:11],
    //   job_kind[34:27], job_duration[50:35], zero fill[55:51]
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    // m_tdata, lowest bit up: status[1:0], out_priority[9:2], out_id[25:10],
    //   out_kind[33:26], out_duration[49:34], occupancy[54:50], zero fill[55]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // Unpack the incoming transaction.
    logic [2:0] in_mode;
    entry_t     in_entry;

    assign in_mode           = s_tdata[2:0];
    assign in_entry.prio     = s_tdata[10:3];
    assign in_entry.id       = s_tdata[26:11];
    assign in_entry.kind     = s_tdata[34:27];
    assign in_entry.duration = s_tdata[50:35];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               scan_search_reg, scan_search_next;
    logic               found_reg, found_next;
    logic [15:0]        key_reg, key_next;
    entry_t             cap_reg, cap_next;
    result_t            res_reg, res_next;
    logic               res_valid_reg, res_valid_next;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    cell_ctrl_t         ctrl;
    entry_t             cell_entry    [QUEUE_DEPTH];
    entry_t             left_entry_w  [QUEUE_DEPTH];
    entry_t             right_entry_w [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] keep_w;
    logic [QUEUE_DEPTH-1:0] left_keep_w;
    logic [QUEUE_DEPTH-1:0] occ_w;

    logic out_free;
    logic res_move;
    logic accept;
    logic res_load;
    logic is_empty;
    logic is_full;
    logic last_step;
    logic scan_go;
    logic hit;

    // ---------------------------------------------------------------- cell chain
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            assign occ_w[gi] = CNT_W'(gi) < count_reg;

            if (gi == 0) begin : g_head
                // The head has nobody in front: a new entry lands here unless it keeps.
                assign left_keep_w[gi]  = 1'b1;
                assign left_entry_w[gi] = ctrl.new_entry;
            end else begin : g_body
                assign left_keep_w[gi]  = keep_w[gi-1];
                assign left_entry_w[gi] = cell_entry[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                // Close the ring so a full rotation restores the order.
                assign right_entry_w[gi] = cell_entry[0];
            end else begin : g_inner
                assign right_entry_w[gi] = cell_entry[gi+1];
            end

            spd_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (occ_w[gi]),
                .left_keep   (left_keep_w[gi]),
                .left_entry  (left_entry_w[gi]),
                .right_entry (right_entry_w[gi]),
                .entry       (cell_entry[gi]),
                .keep        (keep_w[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------- control
    assign out_free  = !m_tvalid_reg || m_tready;
    assign res_move  = res_valid_reg && out_free;
    assign s_tready  = (state_reg == ST_IDLE) && (!res_valid_reg || out_free);
    assign accept    = s_tvalid && s_tready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign last_step = (step_reg == STEP_W'(QUEUE_DEPTH - 1));
    // Hold the last scan step until the staging register can take the result.
    assign scan_go   = !last_step || !res_valid_reg || out_free;

    // The head cell holds original slot step_reg during the scan.
    always_comb begin
        if (scan_search_reg) begin
            hit = !found_reg && (CNT_W'(step_reg) < count_reg)
                  && (cell_entry[0].id == key_reg);
        end else begin
            hit = (CNT_W'(step_reg) == count_reg - CNT_W'(1));
        end
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        scan_search_next = scan_search_reg;
        found_next       = found_reg;
        key_next         = key_reg;
        cap_next         = cap_reg;
        res_next         = res_reg;
        res_load         = 1'b0;
        ctrl.op          = CELL_HOLD;
        ctrl.new_entry   = in_entry;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next.status = STAT_OK;
                    res_next.entry  = '0;
                    res_load        = 1'b1;
                    case (in_mode)
                        MODE_INSERT: begin
                            res_next.entry = in_entry;
                            if (is_full) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_RM_FRONT: begin
                            if (is_empty) begin
                                res_next.status = STAT_EMPTY;
                            end else begin
                                res_next.entry = cell_entry[0];
                                ctrl.op        = CELL_ROTATE;
                                count_next     = count_reg - CNT_W'(1);
                            end
                        end
                        MODE_PEEK: begin
                            if (is_empty) begin
                                res_next.status = STAT_EMPTY;
                            end else begin
                                res_next.entry = cell_entry[0];
                            end
                        end
                        MODE_RM_BACK, MODE_SEARCH: begin
                            if (is_empty) begin
                                res_next.status = (in_mode == MODE_SEARCH) ? STAT_NOT_FOUND
                                                                          : STAT_EMPTY;
                            end else begin
                                // Start a full rotation past the head cell.
                                res_load         = 1'b0;
                                state_next       = ST_SCAN;
                                step_next        = '0;
                                scan_search_next = (in_mode == MODE_SEARCH);
                                found_next       = 1'b0;
                                key_next         = in_entry.id;
                                cap_next         = '0;
                            end
                        end
                        default: begin
                            res_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_go) begin
                    ctrl.op    = CELL_ROTATE;
                    found_next = found_reg || hit;
                    cap_next   = hit ? cell_entry[0] : cap_reg;
                    step_next  = step_reg + STEP_W'(1);
                    if (last_step) begin
                        state_next      = ST_IDLE;
                        res_load        = 1'b1;
                        res_next.entry  = cap_next;
                        if (scan_search_reg) begin
                            res_next.status = found_next ? STAT_OK : STAT_NOT_FOUND;
                        end else begin
                            res_next.status = STAT_OK;
                            count_next      = count_reg - CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.occ   = OCC_W'(count_next);
        res_valid_next = (res_valid_reg && !res_move) || res_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (res_move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        step_reg        <= step_next;
        scan_search_reg <= scan_search_next;
        found_reg       <= found_next;
        key_reg         <= key_next;
        cap_reg         <= cap_next;
        if (res_load) begin
            res_reg <= res_next;
        end
        if (res_move) begin
            m_tdata_reg <= {1'b0, res_reg.occ, res_reg.entry.duration, res_reg.entry.kind,
                            res_reg.entry.id, res_reg.entry.prio, res_reg.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !s_tready)
        else $error("input taken during scan");

    a_rm_front_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_mode == MODE_RM_FRONT) && !is_empty)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove front did not drop the count");

    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && last_step && scan_go)
        |=> ((state_reg == ST_IDLE) && res_valid_reg))
        else $error("scan end did not stage a result");

    a_stage_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !out_free) |=> res_valid_reg)
        else $error("staged result dropped while output stalled");
`endif

endmodule

### design/spd_cell.sv
// One chain slot: holds an entry; insert compares and shifts back; rotate shifts forward.
module spd_cell
    import spd_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       left_keep,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // Stay in place when occupied and not behind the new entry.
    assign keep  = occupied && (entry_reg.prio <= ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        case (ctrl.op)
            CELL_INSERT: begin
                if (keep) begin
                    entry_next = entry_reg;
                end else if (left_keep) begin
                    entry_next = ctrl.new_entry;
                end else begin
                    entry_next = left_entry;
                end
            end
            CELL_ROTATE: entry_next = right_entry;
            default:     entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
